// ----- rtl/core/page_frame_buffer_refresher_assert.svh -----
// Assertion macros for the frame buffer refresher.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef PAGE_FRAME_BUFFER_REFRESHER_ASSERT_SVH
`define PAGE_FRAME_BUFFER_REFRESHER_ASSERT_SVH

`ifndef SYNTH

// Consequent holds in the same cycle as the antecedent
`define PFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfb: same-cycle check failed");

// Consequent holds in the cycle after the antecedent
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfb: next-cycle check failed");

// Consequent holds after a delay from the antecedent
`define PFB_ASSERT_LAT2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error("pfb: two-cycle latency check failed");

`else

`define PFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define PFB_ASSERT_LAT2(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/pfb_pkg.sv -----
package pfb_pkg;

    // Panel command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // Command bytes at the head of each page in the stream
    localparam int HEADER_LEN = 3;

    // Actions of an input item
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_PULL  = 1'b1;

    // Input item
    typedef struct packed {
        logic               action;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic        [15:0] colour;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       is_command;
        logic       frame_end;
    } t_out_item;

    // Stream position decode handed from the sequencer to the datapath
    typedef struct packed {
        logic       is_cmd;
        logic [7:0] cmd_byte;
        logic       frame_end;
    } t_seq_info;

endpackage

// ----- rtl/core/pfb_ram.sv -----
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Registered read returns the old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pfb_seq.sv -----
module pfb_seq
    import pfb_pkg::*;
#(
    parameter int PAGE_COUNT   = 16,
    parameter int COLUMN_COUNT = 64,
    parameter int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
    parameter int CW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    output t_seq_info       o_info,
    output logic [PW-1:0]   o_page,
    output logic [CW-1:0]   o_col
);

    localparam int POS_W = $clog2(COLUMN_COUNT + HEADER_LEN);

    localparam logic [POS_W-1:0] POS_PAGE_CMD = POS_W'(0);
    localparam logic [POS_W-1:0] POS_COL_LOW  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_COL_HIGH = POS_W'(2);
    localparam logic [POS_W-1:0] POS_HEADER   = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(COLUMN_COUNT + HEADER_LEN - 1);
    localparam logic [PW-1:0]    PAGE_LAST    = PW'(PAGE_COUNT - 1);

    logic [PW-1:0]    r_page, n_page;
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [POS_W-1:0] data_pos;

    // Decode the current stream position
    always_comb begin
        o_info.is_cmd    = 1'b1;
        o_info.cmd_byte  = CMD_PAGE_BASE + 8'(r_page);
        o_info.frame_end = 1'b0;
        case (r_pos)
            POS_PAGE_CMD: o_info.cmd_byte = CMD_PAGE_BASE + 8'(r_page);
            POS_COL_LOW:  o_info.cmd_byte = CMD_COL_LOW;
            POS_COL_HIGH: o_info.cmd_byte = CMD_COL_HIGH;
            default: begin
                o_info.is_cmd    = 1'b0;
                o_info.frame_end = (r_page == PAGE_LAST) && (r_pos == POS_LAST);
            end
        endcase
    end

    assign data_pos = r_pos - POS_HEADER;
    assign o_col    = data_pos[CW-1:0];
    assign o_page   = r_page;

    // Advance through the page, then wrap to the next page
    always_comb begin
        n_page = r_page;
        n_pos  = r_pos;
        if (i_advance) begin
            if (r_pos == POS_LAST) begin
                n_pos  = POS_PAGE_CMD;
                n_page = (r_page == PAGE_LAST) ? '0 : r_page + 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_pos  <= POS_PAGE_CMD;
        end else begin
            r_page <= n_page;
            r_pos  <= n_pos;
        end
    end

endmodule

// ----- rtl/core/page_frame_buffer_refresher.sv -----
// Channel   Direction  Handshake                        Payload
// input     in         start high, busy low             i_item  (t_in_item)
// result    out        o_strobe high for one cycle      o_result (t_out_item)
//
// One item is taken every cycle while busy is low; a refresh pull returns its
// byte through the frame store read and stage register, then the result register.
// A pixel write is a read-modify-write through the single frame store port
// pair, with a one-entry bypass so back-to-back writes to one byte chain.
// After reset busy stays high while the frame store, 2**ceil(log2(PAGE_COUNT)) *
// 2**ceil(log2(COLUMN_COUNT)) bytes (1024 by default), is cleared,
// one byte a cycle.
// The receiver cannot stall; results are never held back.
`include "page_frame_buffer_refresher_assert.svh"

module page_frame_buffer_refresher
    import pfb_pkg::*;
#(
    parameter int PAGE_COUNT   = 16,
    parameter int COLUMN_COUNT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW    = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int AW    = PW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [AW-1:0]          ADDR_LAST = AW'(DEPTH - 1);
    localparam logic signed [15:0]     X_MAX     = 16'(COLUMN_COUNT - 1);
    localparam logic signed [15:0]     Y_MAX     = 16'(PAGE_COUNT * 8 - 1);

    typedef struct packed {
        logic            valid;
        logic            pull;
        logic            in_range;
        logic            set_px;
        logic [2:0]      bit_idx;
        logic [AW-1:0]   addr;
        t_seq_info       info;
    } t_stage;

    logic            accept;
    logic            pull_accept;
    t_seq_info       seq_info;
    logic [PW-1:0]   seq_page;
    logic [CW-1:0]   seq_col;

    logic            x_ok, y_ok;
    logic [AW-1:0]   px_addr;
    logic [AW-1:0]   rd_addr;

    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;

    t_stage          r_s1, n_s1;

    logic [7:0]      ram_rdata;
    logic [7:0]      cur_byte;
    logic [7:0]      px_mask;
    logic [7:0]      px_byte;
    logic            px_we;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;

    logic            r_fwd_valid;
    logic [AW-1:0]   r_fwd_addr;
    logic [7:0]      r_fwd_data;

    logic            r_strobe;
    t_out_item       r_result, n_result;

    // Take an item whenever the store is not being cleared
    assign busy        = r_clearing;
    assign accept      = start && !r_clearing;
    assign pull_accept = accept && (i_item.action == ACT_PULL);

    pfb_seq #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT),
        .PW           (PW),
        .CW           (CW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (pull_accept),
        .o_info    (seq_info),
        .o_page    (seq_page),
        .o_col     (seq_col)
    );

    // Decode the pixel coordinates into a store address
    assign x_ok    = (i_item.pixel_x >= 16'sd0) && (i_item.pixel_x <= X_MAX);
    assign y_ok    = (i_item.pixel_y >= 16'sd0) && (i_item.pixel_y <= Y_MAX);
    assign px_addr = {i_item.pixel_y[3 +: PW], i_item.pixel_x[CW-1:0]};
    assign rd_addr = (i_item.action == ACT_PULL) ? {seq_page, seq_col} : px_addr;

    // Capture the accepted item alongside its store read
    always_comb begin
        n_s1          = r_s1;
        n_s1.valid    = accept;
        n_s1.pull     = (i_item.action == ACT_PULL);
        n_s1.in_range = x_ok && y_ok;
        n_s1.set_px   = |i_item.colour;
        n_s1.bit_idx  = i_item.pixel_y[2:0];
        n_s1.addr     = rd_addr;
        n_s1.info     = seq_info;
    end

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Bypass the byte written in the previous cycle
    assign cur_byte = (r_fwd_valid && (r_fwd_addr == r_s1.addr)) ? r_fwd_data : ram_rdata;

    // Modify one bit of the byte for a pixel write
    assign px_mask = 8'b1 << r_s1.bit_idx;
    assign px_byte = r_s1.set_px ? (cur_byte | px_mask) : (cur_byte & ~px_mask);
    assign px_we   = r_s1.valid && !r_s1.pull && r_s1.in_range;

    // Clearing pass owns the write port after reset
    assign ram_we    = r_clearing || px_we;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s1.addr;
    assign ram_wdata = r_clearing ? 8'h00 : px_byte;

    // Form the result byte for a pull
    always_comb begin
        n_result.stream_byte = r_s1.info.is_cmd ? r_s1.info.cmd_byte : cur_byte;
        n_result.is_command  = r_s1.info.is_cmd;
        n_result.frame_end   = r_s1.info.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1.valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            // Sweep the store to zero, then release busy
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1        <= n_s1;
            r_fwd_valid <= px_we;
            r_strobe    <= r_s1.valid && r_s1.pull;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_s1.addr;
        r_fwd_data <= px_byte;
        r_result   <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `PFB_ASSERT_LAT2(a_pull_returns, i_clk, i_rst_n, pull_accept, o_strobe)
    `PFB_ASSERT_LAT2(a_write_silent, i_clk, i_rst_n, accept && (i_item.action == ACT_PIXEL), !o_strobe)
    `PFB_ASSERT_IMPL(a_end_is_data, i_clk, i_rst_n, o_strobe && o_result.frame_end, !o_result.is_command)
    `PFB_ASSERT_NEXT(a_clear_quiet, i_clk, i_rst_n, r_clearing, !r_s1.valid && !r_fwd_valid)

endmodule
